### hdl/windowed_error_restart_monitor_defines.svh
// Assertion macros used by the monitor's top level.
`ifndef WINDOWED_ERROR_RESTART_MONITOR_DEFINES_SVH
`define WINDOWED_ERROR_RESTART_MONITOR_DEFINES_SVH
// Implication checked on every clock edge outside reset.
`define WERM_ASSERT_IMP(label, clk, rst, lhs, rhs) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |-> (rhs)) \
      else $error("assertion failed");
// Implication checked in the cycle after the trigger.
`define WERM_ASSERT_NEXT(label, clk, rst, lhs, rhs) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |=> (rhs)) \
      else $error("assertion failed");
`endif

### hdl/werm_pkg.sv
// Package with constants, types and helpers of the error restart monitor.
`default_nettype none
package werm_pkg;
   localparam int NumContexts = 8;
   localparam int SlotW = (NumContexts > 1) ? $clog2(NumContexts) : 1;

   localparam logic [1:0] FUNC_REPORT = 2'd0;
   localparam logic [1:0] FUNC_ADD    = 2'd1;
   localparam logic [1:0] FUNC_REMOVE = 2'd2;
   localparam logic [1:0] FUNC_CLEAR  = 2'd3;

   localparam logic [1:0] KIND_TIMEOUT   = 2'd1;
   localparam logic [1:0] KIND_DUPLICATE = 2'd2;

   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_PRESENT   = 2'd1;
   localparam logic [1:0] ST_FULL      = 2'd2;
   localparam logic [1:0] ST_NOT_FOUND = 2'd3;

   localparam logic [2:0] REG_WINDOW    = 3'd0;
   localparam logic [2:0] REG_TO_LIMIT  = 3'd1;
   localparam logic [2:0] REG_DUP_LIMIT = 3'd2;
   localparam logic [2:0] REG_ANY_HOLD  = 3'd3;
   localparam logic [2:0] REG_DUP_HOLD  = 3'd4;

   // Per-slot context word held in the memory.
   typedef struct packed {
      logic [31:0] handle;
      logic [31:0] tag;
      logic [63:0] last_restart;
      logic [7:0]  to_count;
      logic [63:0] to_start;
      logic [7:0]  dup_count;
      logic [63:0] dup_start;
   } ctx_type;

   localparam int CtxW = $bits(ctx_type);

   // Configuration registers.
   typedef struct packed {
      logic [31:0] window_ms;
      logic [7:0]  timeout_limit;
      logic [7:0]  duplicate_limit;
      logic [31:0] any_holdoff_ms;
      logic [31:0] duplicate_holdoff_ms;
   } cfg_type;

   // True when now lies before start + len; an end at or beyond all ones counts as zero.
   function automatic logic before_end(input logic [63:0] now, input logic [63:0] start,
                                       input logic [31:0] len);
      logic [64:0] sum;
      logic [63:0] fin;
      sum = {1'b0, start} + {33'd0, len};
      fin = (sum >= 65'h0_FFFF_FFFF_FFFF_FFFF) ? 64'd0 : sum[63:0];
      return now < fin;
   endfunction
endpackage
`default_nettype wire

### hdl/werm_ram.sv
// Generic single-port RAM with registered read.
`default_nettype none
module werm_ram #(
   parameter int Width = 8,
   parameter int Depth = 8
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(Depth > 1 ? Depth : 2)-1:0] addr,
   input  wire logic [Width-1:0]         wr_data,
   output logic      [Width-1:0]         rd_data
);
   logic [Width-1:0] mem [Depth];

   // Write through one port, registered read on the same address.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wr_data;
      end
      rd_data <= mem[addr];
   end
endmodule
`default_nettype wire

### hdl/werm_cfg.sv
// Configuration register file of the monitor.
`default_nettype none
module werm_cfg
   import werm_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [2:0]  csr_index,
   input  wire logic [31:0] csr_data,
   output cfg_type          cfg
);
   cfg_type cfg_ff;

   assign csr_ready = 1'b1;
   assign cfg = cfg_ff;

   // Register writes; unknown indexes are ignored.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{window_ms: 32'd30000, timeout_limit: 8'd7, duplicate_limit: 8'd60,
                     any_holdoff_ms: 32'd60000, duplicate_holdoff_ms: 32'd600000};
      end else if (csr_valid) begin
         unique case (csr_index)
            REG_WINDOW:    cfg_ff.window_ms <= csr_data;
            REG_TO_LIMIT:  cfg_ff.timeout_limit <= csr_data[7:0];
            REG_DUP_LIMIT: cfg_ff.duplicate_limit <= csr_data[7:0];
            REG_ANY_HOLD:  cfg_ff.any_holdoff_ms <= csr_data;
            REG_DUP_HOLD:  cfg_ff.duplicate_holdoff_ms <= csr_data;
            default: ;
         endcase
      end
   end
endmodule
`default_nettype wire

### hdl/windowed_error_restart_monitor.sv
// Top level of the windowed error restart monitor.
//
// Channel  Direction  Contents
// req      in         tdata: func, handle, error_kind, is_open_close, now_ms, client_tag
// rsp      out        tdata: status, restart, tag_out
// csr      in         index and 32-bit write data
//
// A request is scanned with one memory read per slot, the data lagging the address by
// the RAM's read register; then come a read, a compute with write-back of the chosen
// slot and a wait state that loads the output register once it is free. The block then
// returns to idle and takes no new request while one is in progress.
// Reset clears slot valid bits and control registers; data registers and the context memory are not cleared.
// The next request is taken once the result sits in the output register,
// even while that result is stalled; a further result waits in a holding
// register until the output register is free.
`default_nettype none
`include "windowed_error_restart_monitor_defines.svh"
module windowed_error_restart_monitor
   import werm_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   // [1:0] func, [33:2] handle, [35:34] error_kind, [36] is_open_close,
   // [100:37] now_ms, [132:101] client_tag, [135:133] zero
   input  wire logic [135:0] req_tdata,
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   // [1:0] status, [2] restart, [34:3] tag_out, [39:35] zero
   output logic      [39:0]  rsp_tdata,
   input  wire logic         csr_valid,
   output logic              csr_ready,
   input  wire logic [2:0]   csr_index,
   input  wire logic [31:0]  csr_data
);
   typedef enum logic [2:0] {IDLE, SCAN, READ, CALC, WAIT} state_type;

   cfg_type cfg;
   state_type state_ff;
   logic [135:0] req_ff;
   logic [NumContexts-1:0] valid_ff;
   logic [SlotW:0] scan_ff;
   logic [SlotW-1:0] hit_ff, addr;
   logic found_ff;
   logic pend_ff;
   logic [39:0] rsp_ff;
   logic [39:0] res_ff;
   logic wr_en;
   ctx_type rd, wr;

   logic [1:0]  func;
   logic [31:0] handle;
   logic [1:0]  kind;
   logic        oc;
   logic [63:0] now;
   logic [31:0] ctag;
   logic [SlotW-1:0] free_slot;
   logic any_free;

   werm_cfg u_cfg (.clock, .reset, .csr_valid, .csr_ready, .csr_index, .csr_data, .cfg);

   werm_ram #(.Width(CtxW), .Depth(NumContexts)) u_ram (
      .clock, .wr_en, .addr, .wr_data(wr), .rd_data(rd));

   assign func   = req_ff[1:0];
   assign handle = req_ff[33:2];
   assign kind   = req_ff[35:34];
   assign oc     = req_ff[36];
   assign now    = req_ff[100:37];
   assign ctag   = req_ff[132:101];

   assign req_tready = (state_ff == IDLE);
   assign rsp_tvalid = pend_ff;
   assign rsp_tdata  = rsp_ff;

   // Lowest free slot.
   always_comb begin
      free_slot = '0;
      any_free = 1'b0;
      for (int i = NumContexts - 1; i >= 0; i--) begin
         if (!valid_ff[i]) begin
            free_slot = SlotW'(i);
            any_free = 1'b1;
         end
      end
   end

   // Memory address: scan index during the search, else the chosen slot.
   always_comb begin
      if (state_ff == SCAN) begin
         addr = scan_ff[SlotW-1:0];
      end else begin
         addr = hit_ff;
      end
   end

   // Read-modify-write of the chosen slot.
   logic [1:0] status;
   logic restart;
   logic [31:0] tag_out;
   logic in_win;
   logic [7:0] cnt_inc;
   always_comb begin
      wr = rd;
      wr_en = 1'b0;
      status = ST_OK;
      restart = 1'b0;
      tag_out = '0;
      in_win = 1'b0;
      cnt_inc = '0;
      if (func == FUNC_ADD) begin
         if (found_ff) begin
            status = ST_PRESENT;
         end else if (!any_free) begin
            status = ST_FULL;
         end else begin
            wr = '0;
            wr.handle = handle;
            wr.tag = ctag;
            wr_en = (state_ff == CALC);
         end
      end else if (!found_ff) begin
         status = ST_NOT_FOUND;
      end else if (func == FUNC_CLEAR) begin
         wr.to_count = '0;
         wr.to_start = '0;
         wr.dup_count = '0;
         wr.dup_start = '0;
         wr_en = (state_ff == CALC);
      end else if (func == FUNC_REPORT) begin
         tag_out = rd.tag;
         if (kind == KIND_TIMEOUT) begin
            if (oc) begin
               restart = 1'b1;
            end else begin
               in_win = before_end(now, rd.to_start, cfg.window_ms);
               cnt_inc = (rd.to_count == 8'hFF) ? rd.to_count : rd.to_count + 8'd1;
               if (in_win) begin
                  wr.to_count = cnt_inc;
                  restart = cnt_inc >= cfg.timeout_limit;
               end else begin
                  wr.to_start = now;
                  wr.to_count = 8'd1;
               end
            end
         end else if (kind == KIND_DUPLICATE) begin
            in_win = before_end(now, rd.dup_start, cfg.window_ms);
            cnt_inc = (rd.dup_count == 8'hFF) ? rd.dup_count : rd.dup_count + 8'd1;
            if (in_win) begin
               wr.dup_count = cnt_inc;
               restart = (cnt_inc >= cfg.duplicate_limit) &&
                  !before_end(now, rd.last_restart, cfg.duplicate_holdoff_ms);
            end else begin
               wr.dup_start = now;
               wr.dup_count = 8'd1;
            end
         end
         if (restart) begin
            if (before_end(now, rd.last_restart, cfg.any_holdoff_ms)) begin
               restart = 1'b0;
            end else begin
               wr.last_restart = now;
            end
         end
         wr_en = (state_ff == CALC);
      end
   end

   // Sequencer: capture, scan, read, compute and write back.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= IDLE;
         valid_ff <= '0;
         pend_ff <= 1'b0;
         found_ff <= 1'b0;
         scan_ff <= '0;
         hit_ff <= '0;
      end else begin
         // Output register is loaded when free, or emptied when taken.
         if (state_ff == WAIT && (!pend_ff || rsp_tready)) begin
            pend_ff <= 1'b1;
         end else if (pend_ff && rsp_tready) begin
            pend_ff <= 1'b0;
         end
         unique case (state_ff)
            IDLE: begin
               if (req_tvalid) begin
                  req_ff <= req_tdata;
                  scan_ff <= '0;
                  found_ff <= 1'b0;
                  state_ff <= SCAN;
               end
            end
            SCAN: begin
               // Read data belongs to the previous address, delayed by the RAM's read register.
               if (scan_ff != '0 && !found_ff && valid_ff[scan_ff[SlotW-1:0] - 1'b1]
                   && rd.handle == handle) begin
                  found_ff <= 1'b1;
                  hit_ff <= scan_ff[SlotW-1:0] - 1'b1;
               end
               if (scan_ff == (SlotW+1)'(NumContexts)) begin
                  state_ff <= READ;
               end else begin
                  scan_ff <= scan_ff + 1'b1;
               end
            end
            READ: begin
               if (func == FUNC_ADD && !found_ff) begin
                  hit_ff <= free_slot;
               end
               state_ff <= CALC;
            end
            CALC: begin
               state_ff <= WAIT;
               if (func == FUNC_ADD && !found_ff && any_free) begin
                  valid_ff[hit_ff] <= 1'b1;
               end
               if (func == FUNC_REMOVE && found_ff) begin
                  valid_ff[hit_ff] <= 1'b0;
               end
               res_ff <= {5'd0, tag_out, restart, status};
            end
            WAIT: begin
               if (!pend_ff || rsp_tready) begin
                  rsp_ff <= res_ff;
                  state_ff <= IDLE;
               end
            end
            default: state_ff <= IDLE;
         endcase
      end
   end

   `WERM_ASSERT_IMP(a_ready_idle, clock, reset, req_tready, state_ff == IDLE)
   `WERM_ASSERT_NEXT(a_rsp_after_wait, clock, reset,
      state_ff == WAIT && (!pend_ff || rsp_tready), pend_ff)
   `WERM_ASSERT_IMP(a_write_calc, clock, reset, wr_en, state_ff == CALC)
endmodule
`default_nettype wire

### sim/windowed_error_restart_monitor_tb.sv
// Self-checking testbench of the windowed error restart monitor: directed table, then random.
`timescale 1ns / 100ps
`default_nettype none
module windowed_error_restart_monitor_tb;
   import werm_pkg::*;

   typedef struct packed {
      logic [31:0] client_tag;
      logic [63:0] now_ms;
      logic        is_open_close;
      logic [1:0]  error_kind;
      logic [31:0] handle;
      logic [1:0]  func;
   } request_type;

   typedef struct packed {
      logic [31:0] tag_out;
      logic        restart;
      logic [1:0]  status;
   } verdict_type;

   // One row of the directed table; has_verdict marks a typed-in result.
   typedef struct {
      request_type req;
      logic        has_verdict;
      verdict_type verdict;
   } row_type;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [135:0] req_tdata = '0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [39:0]  rsp_tdata;
   logic         csr_valid = 1'b0;
   logic         csr_ready;
   logic [2:0]   csr_index = '0;
   logic [31:0]  csr_data = '0;

   // Predictor copy of configuration and context table.
   logic [31:0] window_len, any_hold, dup_hold;
   logic [7:0]  to_lim, dup_lim;
   logic        ctx_used [NumContexts];
   logic [31:0] ctx_handle [NumContexts];
   logic [31:0] ctx_tag [NumContexts];
   logic [63:0] ctx_last [NumContexts];
   logic [7:0]  ctx_to_cnt [NumContexts];
   logic [63:0] ctx_to_start [NumContexts];
   logic [7:0]  ctx_dup_cnt [NumContexts];
   logic [63:0] ctx_dup_start [NumContexts];

   verdict_type pending_verdicts[$];
   int          fail_count = 0;
   logic [31:0] handle_pool [6] = '{32'h0, 32'hFFFF_FFFF, 32'h1234_5678, 32'hA5A5_5A5A,
                                    32'h8000_0001, 32'h0000_00C3};

   windowed_error_restart_monitor dut (.*);

   always #2 clock = ~clock;

   // Receiver stalls in a rotating pattern with occasional free-running stretches.
   logic [15:0] stall_pattern = 16'hB36D;
   int          stall_phase = 0;
   always @(posedge clock) begin
      stall_phase <= stall_phase + 1;
      if (stall_phase % 200 < 40)
         rsp_tready <= 1'b1;
      else
         rsp_tready <= stall_pattern[stall_phase % 16] | ($urandom_range(0, 3) == 0);
   end

   // Compare each response with the oldest pending verdict.
   always @(posedge clock) begin
      verdict_type got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata[34:0];
         if (pending_verdicts.size() == 0) begin
            $display("%0t: unexpected response, expected none, actual %h", $time, got);
            fail_count++;
         end else begin
            want = pending_verdicts.pop_front();
            if (got.status !== want.status) begin
               $display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
               fail_count++;
            end
            if (got.restart !== want.restart) begin
               $display("%0t: restart expected %0d actual %0d", $time, want.restart,
                        got.restart);
               fail_count++;
            end
            if (got.tag_out !== want.tag_out) begin
               $display("%0t: tag_out expected %h actual %h", $time, want.tag_out,
                        got.tag_out);
               fail_count++;
            end
         end
      end
   end

   // True when now lies before start + len, an end at or beyond all ones counting as zero.
   function automatic logic inside_window(logic [63:0] now, logic [63:0] start,
                                          logic [31:0] len);
      logic [64:0] total;
      total = {1'b0, start} + {33'd0, len};
      if (total >= {1'b0, 64'hFFFF_FFFF_FFFF_FFFF})
         return now < 64'd0;
      return now < total[63:0];
   endfunction

   // Counts one event in a window or opens a new one; true when the count in a running window reaches the limit.
   function automatic logic tally_event(logic [63:0] now, ref logic [63:0] start,
                                        ref logic [7:0] count, input logic [7:0] limit);
      if (inside_window(now, start, window_len)) begin
         if (count != 8'hFF)
            count++;
         return count >= limit;
      end
      start = now;
      count = 8'd1;
      return 1'b0;
   endfunction

   function automatic verdict_type predict_verdict(request_type r);
      verdict_type v;
      int          hit, i;
      v = '0;
      hit = -1;
      for (i = 0; i < NumContexts; i++)
         if (hit < 0 && ctx_used[i] && ctx_handle[i] == r.handle)
            hit = i;
      if (r.func == FUNC_ADD) begin
         if (hit >= 0)
            v.status = ST_PRESENT;
         else begin
            v.status = ST_FULL;
            for (i = 0; i < NumContexts; i++)
               if (v.status == ST_FULL && !ctx_used[i]) begin
                  ctx_used[i] = 1'b1;
                  ctx_handle[i] = r.handle;
                  ctx_tag[i] = r.client_tag;
                  ctx_last[i] = '0;
                  ctx_to_cnt[i] = '0;
                  ctx_to_start[i] = '0;
                  ctx_dup_cnt[i] = '0;
                  ctx_dup_start[i] = '0;
                  v.status = ST_OK;
               end
         end
      end else if (hit < 0)
         v.status = ST_NOT_FOUND;
      else if (r.func == FUNC_REMOVE)
         ctx_used[hit] = 1'b0;
      else if (r.func == FUNC_CLEAR) begin
         ctx_to_cnt[hit] = '0;
         ctx_to_start[hit] = '0;
         ctx_dup_cnt[hit] = '0;
         ctx_dup_start[hit] = '0;
      end else begin
         v.tag_out = ctx_tag[hit];
         if (r.error_kind == KIND_TIMEOUT)
            v.restart = r.is_open_close ? 1'b1 :
               tally_event(r.now_ms, ctx_to_start[hit], ctx_to_cnt[hit], to_lim);
         else if (r.error_kind == KIND_DUPLICATE) begin
            v.restart = tally_event(r.now_ms, ctx_dup_start[hit], ctx_dup_cnt[hit], dup_lim);
            if (v.restart && inside_window(r.now_ms, ctx_last[hit], dup_hold))
               v.restart = 1'b0;
         end
         if (v.restart) begin
            if (inside_window(r.now_ms, ctx_last[hit], any_hold))
               v.restart = 1'b0;
            else
               ctx_last[hit] = r.now_ms;
         end
      end
      return v;
   endfunction

   // Sends one request with its predicted verdict, checking it against the given verdict if one is typed in.
   task automatic send_request(request_type r, logic typed, verdict_type typed_v);
      verdict_type v;
      v = predict_verdict(r);
      if (typed && v !== typed_v) begin
         $display("%0t: table verdict expected %h, predictor gives %h", $time, typed_v, v);
         fail_count++;
      end
      pending_verdicts.push_back(v);
      req_tdata <= {3'b0, r};
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic write_register(logic [2:0] idx, logic [31:0] value);
      csr_index <= idx;
      csr_data <= value;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         REG_WINDOW:    window_len = value;
         REG_TO_LIMIT:  to_lim = value[7:0];
         REG_DUP_LIMIT: dup_lim = value[7:0];
         REG_ANY_HOLD:  any_hold = value;
         REG_DUP_HOLD:  dup_hold = value;
         default: ;
      endcase
   endtask

   // Waits for every pending verdict and lets the block settle.
   task automatic drain_responses();
      req_tvalid <= 1'b0;
      while (pending_verdicts.size() != 0)
         @(posedge clock);
      repeat (NumContexts + 8) @(posedge clock);
   endtask

   function automatic request_type random_request();
      request_type r;
      int          sel;
      r.func = ($urandom_range(0, 9) < 6) ? FUNC_REPORT : 2'($urandom_range(1, 3));
      r.handle = $urandom_range(0, 15) == 0 ? $urandom() : handle_pool[$urandom_range(0, 5)];
      r.error_kind = 2'($urandom_range(0, 3));
      r.is_open_close = $urandom_range(0, 4) == 0;
      r.client_tag = $urandom();
      sel = $urandom_range(0, 19);
      if (sel == 0)
         r.now_ms = {$urandom(), $urandom()};
      else if (sel == 1)
         r.now_ms = 64'hFFFF_FFFF_FFFF_FFFF - $urandom_range(0, 100000);
      else
         r.now_ms = 64'd1000 * $urandom_range(0, 2000);
      return r;
   endfunction

   row_type directed_rows[$];

   function automatic request_type make_request(logic [1:0] f, logic [31:0] h,
                                                logic [1:0] k, logic oc, logic [63:0] now,
                                                logic [31:0] tag);
      request_type r;
      r.func = f;
      r.handle = h;
      r.error_kind = k;
      r.is_open_close = oc;
      r.now_ms = now;
      r.client_tag = tag;
      return r;
   endfunction

   function automatic void add_row(request_type r, logic typed, verdict_type v);
      row_type row;
      row.req = r;
      row.has_verdict = typed;
      row.verdict = v;
      directed_rows.push_back(row);
   endfunction

   initial begin
      int          i, phase;
      request_type r;
      window_len = 32'd30000;
      to_lim = 8'd7;
      dup_lim = 8'd60;
      any_hold = 32'd60000;
      dup_hold = 32'd600000;
      for (i = 0; i < NumContexts; i++)
         ctx_used[i] = 1'b0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      repeat (NumContexts + 8) @(posedge clock);

      // Directed: empty table, fill to full, extremes of time, every kind.
      add_row(make_request(FUNC_REPORT, 32'h0, KIND_TIMEOUT, 1'b1, '0, '0), 1, '{0, 0, ST_NOT_FOUND});
      add_row(make_request(FUNC_REMOVE, 32'hFFFF_FFFF, 0, 0, '0, '0), 1, '{0, 0, ST_NOT_FOUND});
      add_row(make_request(FUNC_CLEAR, 32'h5, 0, 0, '0, '0), 1, '{0, 0, ST_NOT_FOUND});
      for (i = 0; i < NumContexts; i++)
         add_row(make_request(FUNC_ADD, i == 7 ? 32'hFFFF_FFFF : i, 0, 0, '0,
                              i == 7 ? 32'hFFFF_FFFF : 32'hC0DE_0000 + i), 1, '{0, 0, ST_OK});
      add_row(make_request(FUNC_ADD, 32'h1234, 0, 0, '0, '0), 1, '{0, 0, ST_FULL});
      add_row(make_request(FUNC_ADD, 32'h3, 0, 0, '0, '0), 1, '{0, 0, ST_PRESENT});
      add_row(make_request(FUNC_REPORT, 32'hFFFF_FFFF, 2'd3, 1, 64'hFFFF_FFFF_FFFF_FFFF, '0),
              1, '{32'hFFFF_FFFF, 0, ST_OK});
      add_row(make_request(FUNC_REPORT, 32'h0, KIND_TIMEOUT, 1, 64'd70000, '0),
              1, '{32'hC0DE_0000, 1, ST_OK});
      add_row(make_request(FUNC_REPORT, 32'h0, KIND_TIMEOUT, 1, 64'd80000, '0),
              1, '{32'hC0DE_0000, 0, ST_OK});
      add_row(make_request(FUNC_REPORT, 32'h1, 2'd0, 0, 64'd5, '0), 1, '{32'hC0DE_0001, 0, ST_OK});
      add_row(make_request(FUNC_REPORT, 32'h1, KIND_TIMEOUT, 0,
                           64'hFFFF_FFFF_FFFF_FFFF, '0), 0, '0);
      add_row(make_request(FUNC_REPORT, 32'h1, KIND_TIMEOUT, 0,
                           64'hFFFF_FFFF_FFFF_FFFE, '0), 0, '0);
      add_row(make_request(FUNC_REPORT, 32'h2, KIND_DUPLICATE, 0, 64'd100, '0), 0, '0);
      add_row(make_request(FUNC_CLEAR, 32'h2, 0, 0, '0, '0), 1, '{0, 0, ST_OK});
      add_row(make_request(FUNC_REMOVE, 32'h2, 0, 0, '0, '0), 1, '{0, 0, ST_OK});
      add_row(make_request(FUNC_REPORT, 32'h2, KIND_DUPLICATE, 0, 64'd100, '0),
              1, '{0, 0, ST_NOT_FOUND});
      add_row(make_request(FUNC_ADD, 32'h2, 0, 0, '0, 32'h0BAD_F00D), 1, '{0, 0, ST_OK});
      foreach (directed_rows[i])
         send_request(directed_rows[i].req, directed_rows[i].has_verdict,
                      directed_rows[i].verdict);
      drain_responses();

      // Random phases, each under a different configuration.
      for (phase = 0; phase < 6; phase++) begin
         case (phase)
            0: begin
               write_register(REG_TO_LIMIT, 8'd1);
               write_register(REG_DUP_LIMIT, 8'd2);
               write_register(REG_ANY_HOLD, 32'd0);
               write_register(REG_DUP_HOLD, 32'd0);
            end
            1: begin
               write_register(REG_WINDOW, 32'hFFFF_FFFF);
               write_register(REG_TO_LIMIT, 8'd255);
               write_register(REG_DUP_LIMIT, 8'd255);
               write_register(REG_ANY_HOLD, 32'hFFFF_FFFF);
               write_register(REG_DUP_HOLD, 32'hFFFF_FFFF);
            end
            2: begin
               write_register(REG_WINDOW, 32'd1);
               write_register(REG_TO_LIMIT, 8'd1);
               write_register(REG_DUP_LIMIT, 8'd1);
               write_register(REG_ANY_HOLD, 32'd0);
            end
            default: begin
               write_register(REG_WINDOW, $urandom_range(1000, 500000));
               write_register(REG_TO_LIMIT, $urandom_range(1, 6));
               write_register(REG_DUP_LIMIT, $urandom_range(1, 8));
               write_register(REG_ANY_HOLD, $urandom_range(0, 100000));
               write_register(REG_DUP_HOLD, $urandom_range(0, 300000));
            end
         endcase
         i = 0;
         while (i < 155) begin
            int burst;
            burst = $urandom_range(1, 12);
            repeat (burst) begin
               r = random_request();
               send_request(r, 1'b0, '0);
               i++;
            end
            if ($urandom_range(0, 2) != 0) begin
               req_tvalid <= 1'b0;
               repeat ($urandom_range(1, 30)) @(posedge clock);
            end
         end
         drain_responses();
      end

      if (fail_count == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

   // Hard limit on run time.
   initial begin
      #2000000;
      $display("Verification failed");
      $finish;
   end
endmodule
`default_nettype wire

### sim.f
+incdir+hdl
hdl/werm_pkg.sv
hdl/werm_ram.sv
hdl/werm_cfg.sv
hdl/windowed_error_restart_monitor.sv
sim/windowed_error_restart_monitor_tb.sv
